### rtl/pfa_pkg.sv
// Package for the pose frame accumulator: operand codes, the sequencer's
// step table, the CORDIC arctangent table and fixed-format constants.
// No dependencies.
package pfa_pkg;

	// Width of sines, cosines and their products inside the datapath.
	localparam int TRIG_W = 34;
	// Number of multiply-accumulate steps in the sequencer program.
	localparam int STEP_COUNT = 51;
	localparam logic [5:0] STEP_ROW_LAST = 6'd8;
	localparam logic [5:0] STEP_LAST = 6'd50;
	localparam int OP_COUNT = 43;
	// One in Q2.30 and the CORDIC gain compensation in Q2.30.
	localparam int ONE_Q30 = 1 << 30;
	localparam int CORDIC_GAIN_Q30 = 652032874;
	localparam int ROUND_HALF = 1 << 29;

	// Operand and destination codes of the shared multiply-accumulate unit.
	typedef enum logic [5:0] {
		OP_R0 = 6'd0, OP_R1 = 6'd1, OP_R2 = 6'd2, OP_R3 = 6'd3, OP_R4 = 6'd4,
		OP_R5 = 6'd5, OP_R6 = 6'd6, OP_R7 = 6'd7, OP_R8 = 6'd8,
		OP_T0 = 6'd9, OP_T1 = 6'd10, OP_T2 = 6'd11,
		OP_P0 = 6'd12, OP_P1 = 6'd13, OP_P2 = 6'd14,
		OP_CA = 6'd15, OP_SA = 6'd16, OP_CB = 6'd17, OP_SB = 6'd18,
		OP_CG = 6'd19, OP_SG = 6'd20,
		OP_CBSG = 6'd21, OP_SBSG = 6'd22,
		OP_M0 = 6'd23, OP_M1 = 6'd24, OP_M2 = 6'd25, OP_M3 = 6'd26, OP_M4 = 6'd27,
		OP_M5 = 6'd28, OP_M6 = 6'd29, OP_M7 = 6'd30, OP_M8 = 6'd31,
		OP_N0 = 6'd32, OP_N1 = 6'd33, OP_N2 = 6'd34, OP_N3 = 6'd35, OP_N4 = 6'd36,
		OP_N5 = 6'd37, OP_N6 = 6'd38, OP_N7 = 6'd39, OP_N8 = 6'd40,
		OP_ONE = 6'd41, OP_ZERO = 6'd42
	} opnd_t;

	// One step: acc = (first ? base : acc) +/- mul30(a, b); written to dst on last.
	typedef struct packed {
		opnd_t a;
		opnd_t b;
		logic neg;
		logic first;
		logic init_t;
		logic last;
		opnd_t dst;
	} step_t;

	function automatic step_t mk_step(input opnd_t a, input opnd_t b, input logic neg,
		input logic first, input logic last, input opnd_t dst);
		step_t s;
		s.a = a;
		s.b = b;
		s.neg = neg;
		s.first = first;
		s.init_t = 1'b0;
		s.last = last;
		s.dst = dst;
		return s;
	endfunction

	// Sequencer program. Steps 0-8 form R*p + t, one row per three steps.
	// Steps 9-23 build M from the sines and cosines, steps 24-50 form R*M.
	function automatic step_t step_rom(input logic [5:0] pc);
		step_t s;
		s = mk_step(OP_ZERO, OP_ZERO, 1'b0, 1'b1, 1'b1, OP_CBSG);
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				if (pc == 6'(r * 3 + k)) begin
					s = mk_step(opnd_t'(OP_R0 + r * 3 + k), opnd_t'(OP_P0 + k), 1'b0,
						k == 0, k == 2, opnd_t'(OP_T0 + r));
					s.init_t = (k == 0);
				end
			end
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					if (pc == 6'(24 + r * 9 + c * 3 + k)) begin
						s = mk_step(opnd_t'(OP_R0 + r * 3 + k), opnd_t'(OP_M0 + k * 3 + c),
							1'b0, k == 0, k == 2, opnd_t'(OP_N0 + r * 3 + c));
					end
				end
			end
		end
		case (pc)
			6'd9: s = mk_step(OP_CB, OP_SG, 1'b0, 1'b1, 1'b1, OP_CBSG);
			6'd10: s = mk_step(OP_SB, OP_SG, 1'b0, 1'b1, 1'b1, OP_SBSG);
			6'd11: s = mk_step(OP_CB, OP_CG, 1'b0, 1'b1, 1'b1, OP_M0);
			6'd12: s = mk_step(OP_CBSG, OP_SA, 1'b0, 1'b1, 1'b0, OP_M1);
			6'd13: s = mk_step(OP_SB, OP_CA, 1'b1, 1'b0, 1'b1, OP_M1);
			6'd14: s = mk_step(OP_CBSG, OP_CA, 1'b0, 1'b1, 1'b0, OP_M2);
			6'd15: s = mk_step(OP_SB, OP_SA, 1'b0, 1'b0, 1'b1, OP_M2);
			6'd16: s = mk_step(OP_SB, OP_CG, 1'b0, 1'b1, 1'b1, OP_M3);
			6'd17: s = mk_step(OP_SBSG, OP_SA, 1'b0, 1'b1, 1'b0, OP_M4);
			6'd18: s = mk_step(OP_CB, OP_CA, 1'b0, 1'b0, 1'b1, OP_M4);
			6'd19: s = mk_step(OP_SBSG, OP_CA, 1'b0, 1'b1, 1'b0, OP_M5);
			6'd20: s = mk_step(OP_CB, OP_SA, 1'b1, 1'b0, 1'b1, OP_M5);
			6'd21: s = mk_step(OP_SG, OP_ONE, 1'b1, 1'b1, 1'b1, OP_M6);
			6'd22: s = mk_step(OP_CG, OP_SA, 1'b0, 1'b1, 1'b1, OP_M7);
			6'd23: s = mk_step(OP_CG, OP_CA, 1'b0, 1'b1, 1'b1, OP_M8);
			default: ;
		endcase
		return s;
	endfunction

	// atan(2^-i) in units of 2^32 per turn.
	function automatic logic [31:0] atan_step(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

### rtl/pfa_if.sv
// Channel interfaces of the pose frame accumulator: command beats in,
// transformed point beats out. Valid/ready handshake. No dependencies.
interface pfa_in_if #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic func;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic signed [ANGLE_WIDTH-1:0] roll_angle;
	logic signed [ANGLE_WIDTH-1:0] yaw_angle;
	logic signed [ANGLE_WIDTH-1:0] pitch_angle;

	modport source (output valid, func, pos_x, pos_y, pos_z, roll_angle, yaw_angle,
		pitch_angle, input ready);
	modport sink (input valid, func, pos_x, pos_y, pos_z, roll_angle, yaw_angle,
		pitch_angle, output ready);
endinterface

interface pfa_out_if #(
	parameter int COORD_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic signed [COORD_WIDTH-1:0] out_z;
	logic saturated;

	modport source (output valid, out_x, out_y, out_z, saturated, input ready);
	modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

### rtl/pose_frame_accumulator.sv
// A point beat runs 9 multiply steps, each through MUL1 and MUL2, then the emit state.
// A compose beat runs 51 multiply steps, with the CORDIC rotations of the three angles
// between steps 8 and 9; both use the single shared multiply-accumulate unit, and a compose
// beat also the single CORDIC stage. One beat is in work at a time.
// Reset (arst_n low, asynchronous) sets the rotation to the identity, the translation to zero.
module pose_frame_accumulator #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	pfa_in_if.sink cmd,
	pfa_out_if.source rsp
);
	import pfa_pkg::*;

	// Pool width: wide enough for a coordinate and for a trig value.
	localparam int PW = (COORD_WIDTH > TRIG_W) ? COORD_WIDTH : TRIG_W;
	localparam int BH_W = PW - 16;
	localparam int ACC_W = PW + 6;
	localparam int LOW_W = TRIG_W + 2;
	localparam int LO_P_W = TRIG_W + 17;
	localparam int HI_P_W = TRIG_W + BH_W + 1;
	localparam int IT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_STEPS - 1);
	localparam logic signed [ACC_W-1:0] ONE_A = ACC_W'(1);
	localparam logic signed [ACC_W-1:0] MAX32 = (ONE_A <<< 31) - ONE_A;
	localparam logic signed [ACC_W-1:0] MIN32 = -MAX32 - ONE_A;
	localparam logic signed [ACC_W-1:0] MAXC = (ONE_A <<< (COORD_WIDTH - 1)) - ONE_A;
	localparam logic signed [ACC_W-1:0] MINC = -MAXC - ONE_A;

	// The sequencer walks through one-hot states. Each multiply step runs in two states:
	// the low partial product in MUL1, the high one with accumulation in MUL2.
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL1 = 5'b00010,
		ST_MUL2 = 5'b00100,
		ST_CORD = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;
	logic [5:0] pc_q;
	logic func_q;
	logic signed [COORD_WIDTH-1:0] p_q [3];
	logic signed [ANGLE_WIDTH-1:0] ang_q [3];
	logic signed [31:0] r_q [9];
	logic signed [COORD_WIDTH-1:0] t_q [3];
	logic signed [31:0] m_q [9];
	logic signed [31:0] n_q [9];
	logic signed [TRIG_W-1:0] trig_q [6];
	logic signed [TRIG_W-1:0] cbsg_q;
	logic signed [TRIG_W-1:0] sbsg_q;
	logic signed [COORD_WIDTH-1:0] res_q [3];
	logic clip_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [LOW_W-1:0] low_q;
	logic signed [TRIG_W-1:0] cx_q;
	logic signed [TRIG_W-1:0] cy_q;
	logic signed [32:0] cz_q;
	logic [IT_W-1:0] it_q;
	logic [1:0] ang_sel_q;
	logic flip_q;
	logic signed [COORD_WIDTH-1:0] out_x_q;
	logic signed [COORD_WIDTH-1:0] out_y_q;
	logic signed [COORD_WIDTH-1:0] out_z_q;
	logic out_sat_q;
	logic out_valid_q;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] s;
		if (v > MAX32) s = 32'sh7FFFFFFF;
		else if (v < MIN32) s = 32'sh80000000;
		else s = v[31:0];
		return s;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] satc(input logic signed [ACC_W-1:0] v);
		logic signed [COORD_WIDTH-1:0] s;
		if (v > MAXC) s = MAXC[COORD_WIDTH-1:0];
		else if (v < MINC) s = MINC[COORD_WIDTH-1:0];
		else s = v[COORD_WIDTH-1:0];
		return s;
	endfunction

	// Operand pool: every value the multiply unit can read, widened to PW bits.
	logic signed [PW-1:0] pool [OP_COUNT];
	always_comb begin
		pool = '{default: '0};
		for (int i = 0; i < 9; i++) begin
			pool[OP_R0 + i] = PW'(r_q[i]);
			pool[OP_M0 + i] = PW'(m_q[i]);
			pool[OP_N0 + i] = PW'(n_q[i]);
		end
		for (int i = 0; i < 3; i++) begin
			pool[OP_T0 + i] = PW'(t_q[i]);
			pool[OP_P0 + i] = PW'(p_q[i]);
		end
		for (int i = 0; i < 6; i++) begin
			pool[OP_CA + i] = PW'(trig_q[i]);
		end
		pool[OP_CBSG] = PW'(cbsg_q);
		pool[OP_SBSG] = PW'(sbsg_q);
		pool[OP_ONE] = PW'(ONE_Q30);
		pool[OP_ZERO] = '0;
	end

	// Shared multiply-accumulate unit computing floor((a*b + 2^29) / 2^30)
	// in two partial products: a times the low 16 bits of b, then the high part.
	step_t st;
	logic signed [TRIG_W-1:0] a_op;
	logic signed [PW-1:0] b_op;
	logic signed [16:0] b_lo;
	logic signed [BH_W-1:0] b_hi;
	logic signed [LO_P_W-1:0] prod_lo;
	logic signed [LO_P_W-1:0] sum_lo;
	logic signed [LOW_W-1:0] low_d;
	logic signed [HI_P_W-1:0] prod_hi;
	logic signed [HI_P_W-1:0] sum_hi;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] acc_d;
	logic row_clip;

	assign st = step_rom(pc_q);
	assign a_op = TRIG_W'(pool[st.a]);
	assign b_op = pool[st.b];
	assign b_lo = {1'b0, b_op[15:0]};
	assign b_hi = b_op[PW-1:16];
	assign prod_lo = LO_P_W'(a_op * b_lo);
	assign sum_lo = prod_lo + LO_P_W'(ROUND_HALF);
	assign low_d = LOW_W'(sum_lo >>> 16);
	assign prod_hi = HI_P_W'(a_op * b_hi);
	assign sum_hi = prod_hi + HI_P_W'(low_q);
	assign term = ACC_W'(sum_hi >>> 14);
	assign base = st.first ? (st.init_t ? ACC_W'(pool[st.dst]) : '0) : acc_q;
	assign acc_d = st.neg ? (base - term) : (base + term);
	assign row_clip = (acc_d > MAXC) || (acc_d < MINC);

	// CORDIC stage: one rotation step per cycle. The angle is first widened to a
	// 32-bit binary angle; angles beyond a quarter turn are turned by a half turn
	// and the outputs negated at the end.
	logic [1:0] ld_sel;
	logic [31:0] ld_u;
	logic ld_flip;
	logic [31:0] ld_uf;
	logic signed [TRIG_W-1:0] dx;
	logic signed [TRIG_W-1:0] dy;
	logic signed [32:0] dz;
	logic cdir;
	logic signed [TRIG_W-1:0] nx;
	logic signed [TRIG_W-1:0] ny;
	logic signed [32:0] nz;

	// After the last angle there is nothing left to load, so the selector stays at zero.
	assign ld_sel = (state_q == ST_CORD && ang_sel_q != 2'd2) ? (ang_sel_q + 2'd1) : 2'd0;
	assign ld_u = {ang_q[ld_sel], (32 - ANGLE_WIDTH)'(0)};
	assign ld_flip = (ld_u > 32'h40000000) && (ld_u < 32'hC0000000);
	assign ld_uf = ld_flip ? (ld_u + 32'h80000000) : ld_u;
	assign dx = cy_q >>> it_q;
	assign dy = cx_q >>> it_q;
	assign dz = {1'b0, atan_step(5'(it_q))};
	assign cdir = !cz_q[32];
	assign nx = cdir ? (cx_q - dx) : (cx_q + dx);
	assign ny = cdir ? (cy_q + dy) : (cy_q - dy);
	assign nz = cdir ? (cz_q - dz) : (cz_q + dz);

	assign cmd.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.out_x = out_x_q;
	assign rsp.out_y = out_y_q;
	assign rsp.out_z = out_z_q;
	assign rsp.saturated = out_sat_q;

	// Control state and the stored transform.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			ang_sel_q <= '0;
			it_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				r_q[i] <= (i % 4 == 0) ? 32'(ONE_Q30) : 32'sd0;
			end
			for (int i = 0; i < 3; i++) begin
				t_q[i] <= '0;
			end
		end else begin
			// A new point beat loads the output register once it is free or draining.
			if (state_q == ST_EMIT && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						pc_q <= '0;
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					pc_q <= pc_q + 6'd1;
					if (st.last) begin
						for (int i = 0; i < 3; i++) begin
							if (st.dst == opnd_t'(OP_T0 + i) && !func_q) begin
								t_q[i] <= satc(acc_d);
							end
						end
					end
					if (pc_q == STEP_ROW_LAST) begin
						if (func_q) begin
							state_q <= ST_EMIT;
						end else begin
							ang_sel_q <= '0;
							it_q <= '0;
							state_q <= ST_CORD;
						end
					end else if (pc_q == STEP_LAST) begin
						// The last step's product lands in the final entry directly.
						for (int i = 0; i < 8; i++) begin
							r_q[i] <= n_q[i];
						end
						r_q[8] <= sat32(acc_d);
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MUL1;
					end
				end
				ST_CORD: begin
					it_q <= it_q + IT_W'(1);
					if (it_q == IT_LAST) begin
						it_q <= '0;
						ang_sel_q <= ang_sel_q + 2'd1;
						if (ang_sel_q == 2'd2) begin
							state_q <= ST_MUL1;
						end
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					func_q <= cmd.func;
					p_q[0] <= cmd.pos_x;
					p_q[1] <= cmd.pos_y;
					p_q[2] <= cmd.pos_z;
					ang_q[0] <= cmd.roll_angle;
					ang_q[1] <= cmd.yaw_angle;
					ang_q[2] <= cmd.pitch_angle;
					clip_q <= 1'b0;
				end
			end
			ST_MUL1: begin
				low_q <= low_d;
			end
			ST_MUL2: begin
				acc_q <= acc_d;
				if (st.last) begin
					for (int i = 0; i < 3; i++) begin
						if (st.dst == opnd_t'(OP_T0 + i)) begin
							res_q[i] <= satc(acc_d);
							if (row_clip) begin
								clip_q <= 1'b1;
							end
						end
					end
					for (int i = 0; i < 9; i++) begin
						if (st.dst == opnd_t'(OP_M0 + i)) begin
							m_q[i] <= sat32(acc_d);
						end
						if (st.dst == opnd_t'(OP_N0 + i)) begin
							n_q[i] <= sat32(acc_d);
						end
					end
					if (st.dst == OP_CBSG) begin
						cbsg_q <= TRIG_W'(acc_d);
					end
					if (st.dst == OP_SBSG) begin
						sbsg_q <= TRIG_W'(acc_d);
					end
				end
				if (pc_q == STEP_ROW_LAST && !func_q) begin
					cx_q <= TRIG_W'(CORDIC_GAIN_Q30);
					cy_q <= '0;
					cz_q <= 33'(signed'(ld_uf));
					flip_q <= ld_flip;
				end
			end
			ST_CORD: begin
				if (it_q == IT_LAST) begin
					trig_q[{ang_sel_q, 1'b0}] <= flip_q ? -nx : nx;
					trig_q[{ang_sel_q, 1'b1}] <= flip_q ? -ny : ny;
					cx_q <= TRIG_W'(CORDIC_GAIN_Q30);
					cy_q <= '0;
					cz_q <= 33'(signed'(ld_uf));
					flip_q <= ld_flip;
				end else begin
					cx_q <= nx;
					cy_q <= ny;
					cz_q <= nz;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					out_x_q <= res_q[0];
					out_y_q <= res_q[1];
					out_z_q <= res_q[2];
					out_sat_q <= clip_q;
				end
			end
			default: ;
		endcase
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for pose_frame_accumulator: compose and point beats in,
// predicted transformed points compared field by field. Depends on rtl/pfa_pkg.sv,
// rtl/pfa_if.sv and rtl/pose_frame_accumulator.sv.
module tb_top;
	import pfa_pkg::*;

	localparam int CW = 32;
	localparam int AW = 16;
	localparam int STEPS = 16;
	localparam logic FUNC_COMPOSE = 1'b0;
	localparam logic FUNC_POINT = 1'b1;
	// Slack after the last result, for a compose beat still in work.
	localparam int DRAIN_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic func;
		logic signed [CW-1:0] px, py, pz;
		logic signed [AW-1:0] roll, yaw, pitch;
	} cmd_beat_t;

	typedef struct {
		logic signed [CW-1:0] x, y, z;
		logic sat;
	} point_beat_t;

	logic clk;
	logic arst_n;
	pfa_in_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) cmd();
	pfa_out_if #(.COORD_WIDTH(CW)) rsp();

	pose_frame_accumulator #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW), .CORDIC_STEPS(STEPS))
		u_top (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Pending command beats, and the transformed points still owed by the block.
	cmd_beat_t pending_cmds[$];
	point_beat_t owed_points[$];
	int error_count = 0;
	bit stim_done = 0;
	// When set, the driver holds off until every owed point has come back.
	bit hold_for_drain = 0;
	// Set at a rising edge where the command beat was taken.
	bit cmd_taken = 0;

	// Predictor state: the pose as wide integers, clipped to the ranges the block uses.
	longint pose_rot[9];
	longint pose_trans[3];

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// Product of a Q2.30 value with any value, rounded half up, computed without overflow.
	function automatic longint q30_mul(longint a, longint b);
		longint hi, lo, part;
		hi = floor_shr(b, 16);
		lo = b & 64'hFFFF;
		part = floor_shr(a * lo + (64'sd1 <<< 29), 16);
		return floor_shr(a * hi + part, 14);
	endfunction

	function automatic longint clip_to(longint v, int w, inout bit clipped);
		longint hi, lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clipped = 1;
			return hi;
		end
		if (v < lo) begin
			clipped = 1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint clip32(longint v);
		bit unused;
		unused = 0;
		return clip_to(v, 32, unused);
	endfunction

	// Rotation-mode CORDIC; angles beyond a quarter turn are folded by a half turn.
	task automatic sin_cos(input logic [AW-1:0] ang, output longint c, output longint s);
		logic [31:0] u;
		bit flip;
		longint x, y, z, dx, dy;
		u = {ang, {(32 - AW){1'b0}}};
		flip = 0;
		x = CORDIC_GAIN_Q30;
		y = 0;
		if (u > 32'h40000000 && u < 32'hC0000000) begin
			u = u + 32'h80000000;
			flip = 1;
		end
		z = longint'($signed(u));
		for (int i = 0; i < STEPS && i < 30; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_step(5'(i)));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_step(5'(i)));
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endtask

	task automatic reset_pose();
		for (int i = 0; i < 9; i++)
			pose_rot[i] = (i % 4 == 0) ? (64'sd1 <<< 30) : 0;
		for (int i = 0; i < 3; i++)
			pose_trans[i] = 0;
	endtask

	// Applies one accepted command beat to the pose and queues any owed point.
	task automatic update_pose(input cmd_beat_t b);
		longint p[3], acc[3], m[9], nr[9];
		longint ca, sa, cb, sb, cg, sg, cbsg, sbsg, sum;
		bit clipped;
		point_beat_t pt;
		p[0] = b.px;
		p[1] = b.py;
		p[2] = b.pz;
		clipped = 0;
		for (int r = 0; r < 3; r++) begin
			acc[r] = pose_trans[r];
			for (int k = 0; k < 3; k++)
				acc[r] += q30_mul(pose_rot[r * 3 + k], p[k]);
		end
		if (b.func == FUNC_POINT) begin
			pt.x = CW'(clip_to(acc[0], CW, clipped));
			pt.y = CW'(clip_to(acc[1], CW, clipped));
			pt.z = CW'(clip_to(acc[2], CW, clipped));
			pt.sat = clipped;
			owed_points.push_back(pt);
			return;
		end
		sin_cos(b.roll, ca, sa);
		sin_cos(b.yaw, cb, sb);
		sin_cos(b.pitch, cg, sg);
		cbsg = q30_mul(cb, sg);
		sbsg = q30_mul(sb, sg);
		m[0] = clip32(q30_mul(cb, cg));
		m[1] = clip32(q30_mul(cbsg, sa) - q30_mul(sb, ca));
		m[2] = clip32(q30_mul(cbsg, ca) + q30_mul(sb, sa));
		m[3] = clip32(q30_mul(sb, cg));
		m[4] = clip32(q30_mul(sbsg, sa) + q30_mul(cb, ca));
		m[5] = clip32(q30_mul(sbsg, ca) - q30_mul(cb, sa));
		m[6] = clip32(-sg);
		m[7] = clip32(q30_mul(cg, sa));
		m[8] = clip32(q30_mul(cg, ca));
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				sum = 0;
				for (int k = 0; k < 3; k++)
					sum += q30_mul(pose_rot[r * 3 + k], m[k * 3 + c]);
				nr[r * 3 + c] = clip32(sum);
			end
		pose_rot = nr;
		// Translation clips silently; compose gives no result.
		for (int r = 0; r < 3; r++)
			pose_trans[r] = clip_to(acc[r], CW, clipped);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(0, 131072)) - 65536);
			3, 4, 5: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
			default: return $urandom();
		endcase
	endfunction

	function automatic cmd_beat_t make_beat(logic f, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [15:0] a, logic [15:0] yw, logic [15:0] g);
		cmd_beat_t b;
		b.func = f;
		b.px = x;
		b.py = y;
		b.pz = z;
		b.roll = a;
		b.yaw = yw;
		b.pitch = g;
		return b;
	endfunction

	function automatic cmd_beat_t rand_beat();
		// Points outnumber poses so results are plentiful; translations are drawn like
		// point coordinates, the rails included.
		if ($urandom_range(0, 2) != 0)
			return make_beat(FUNC_POINT, rand_coord(), rand_coord(), rand_coord(),
				16'($urandom()), 16'($urandom()), 16'($urandom()));
		return make_beat(FUNC_COMPOSE, rand_coord(), rand_coord(), rand_coord(),
			16'($urandom()), 16'($urandom()), 16'($urandom()));
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Stimulus: directed corners first, then random beats with one forced drain.
	initial begin
		reset_pose();
		// Identity pose passes points through, the extremes included.
		pending_cmds.push_back(make_beat(FUNC_POINT, 32'h7FFFFFFF, 32'h80000000, 32'h0,
			16'h7FFF, 16'h8000, 16'hFFFF));
		pending_cmds.push_back(make_beat(FUNC_POINT, 32'hFFFFFFFF, 32'h00010000, 32'h1,
			16'h0, 16'h0, 16'h0));
		// Pure translation up to the rail, then a point that clips.
		pending_cmds.push_back(make_beat(FUNC_COMPOSE, 32'h7FFFFFFF, 32'h80000000,
			32'h00010000, 16'h0, 16'h0, 16'h0));
		pending_cmds.push_back(make_beat(FUNC_POINT, 32'h00010000, 32'hFFFF0000, 32'h0,
			16'h0, 16'h0, 16'h0));
		// Translation that itself clips silently.
		pending_cmds.push_back(make_beat(FUNC_COMPOSE, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 16'h0, 16'h0, 16'h0));
		pending_cmds.push_back(make_beat(FUNC_POINT, 32'h0, 32'h0, 32'h0,
			16'h1234, 16'h4321, 16'h7FFF));
		// Angles at the quarter and half turns and the folded range edges.
		pending_cmds.push_back(make_beat(FUNC_COMPOSE, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 16'h4000, 16'h0, 16'h0));
		pending_cmds.push_back(make_beat(FUNC_POINT, 32'h00010000, 32'h00010000,
			32'h00010000, 16'h0, 16'h0, 16'h0));
		pending_cmds.push_back(make_beat(FUNC_COMPOSE, 32'h0, 32'h0, 32'h0,
			16'h8000, 16'hC000, 16'h4001));
		pending_cmds.push_back(make_beat(FUNC_COMPOSE, 32'h0, 32'h0, 32'h0,
			16'h7FFF, 16'h8001, 16'hBFFF));
		pending_cmds.push_back(make_beat(FUNC_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_cmds.push_back(make_beat(FUNC_COMPOSE, 32'h00050000, 32'hFFFB0000,
			32'h00000001, 16'h2000, 16'hE000, 16'h1555));
		pending_cmds.push_back(make_beat(FUNC_POINT, 32'h80000000, 32'h80000000,
			32'h80000000, 16'h0, 16'h0, 16'h0));
		pending_cmds.push_back(make_beat(FUNC_POINT, 32'h00030000, 32'hFFFD8000,
			32'h0000C000, 16'h0, 16'h0, 16'h0));
		for (int i = 0; i < 950; i++) begin
			if (i == 400) begin
				wait (pending_cmds.size() == 0);
				hold_for_drain = 1;
			end
			pending_cmds.push_back(rand_beat());
		end
		stim_done = 1;
	end

	// The block drops ready right after a take, so the handshake is caught at the
	// rising edge itself.
	always @(posedge clk) begin
		cmd_taken <= arst_n && cmd.valid && cmd.ready;
	end

	// Driver: presents queued beats at falling edges with random gaps.
	int gap_left = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			gap_left <= 0;
		end else if (cmd.valid && cmd_taken) begin
			// The beat at the head went through at the last rising edge.
			update_pose(pending_cmds.pop_front());
			cmd.valid <= 1'b0;
			gap_left <= gap_len();
		end else if (!cmd.valid) begin
			if (gap_left > 0)
				gap_left <= gap_left - 1;
			else if (hold_for_drain && owed_points.size() != 0)
				;
			else if (pending_cmds.size() != 0) begin
				hold_for_drain <= 0;
				cmd.valid <= 1'b1;
				cmd.func <= pending_cmds[0].func;
				cmd.pos_x <= pending_cmds[0].px;
				cmd.pos_y <= pending_cmds[0].py;
				cmd.pos_z <= pending_cmds[0].pz;
				cmd.roll_angle <= pending_cmds[0].roll;
				cmd.yaw_angle <= pending_cmds[0].yaw;
				cmd.pitch_angle <= pending_cmds[0].pitch;
			end
		end
	end

	// Result stall generator, also on the falling edge.
	int stall_left = 0;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			rsp.ready <= 1'b0;
			stall_left <= gap_len();
		end else
			rsp.ready <= 1'b1;
	end

	// Monitor: checks each accepted point beat against the oldest owed point.
	always @(posedge clk) begin
		point_beat_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (owed_points.size() == 0) begin
				$display("%0t: unexpected point beat x=%h y=%h z=%h sat=%b", $realtime,
					rsp.out_x, rsp.out_y, rsp.out_z, rsp.saturated);
				error_count++;
			end else begin
				want = owed_points.pop_front();
				if (rsp.out_x !== want.x) begin
					$display("%0t: out_x expected %h actual %h", $realtime, want.x, rsp.out_x);
					error_count++;
				end
				if (rsp.out_y !== want.y) begin
					$display("%0t: out_y expected %h actual %h", $realtime, want.y, rsp.out_y);
					error_count++;
				end
				if (rsp.out_z !== want.z) begin
					$display("%0t: out_z expected %h actual %h", $realtime, want.z, rsp.out_z);
					error_count++;
				end
				if (rsp.saturated !== want.sat) begin
					$display("%0t: saturated expected %b actual %b", $realtime, want.sat,
						rsp.saturated);
					error_count++;
				end
			end
		end
	end

	// Cycle limit: the slowest correct run is about 1000 composes plus long gaps
	// and stalls, well under this.
	longint cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		cmd.valid = 1'b0;
		cmd.func = FUNC_COMPOSE;
		cmd.pos_x = '0;
		cmd.pos_y = '0;
		cmd.pos_z = '0;
		cmd.roll_angle = '0;
		cmd.yaw_angle = '0;
		cmd.pitch_angle = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done && pending_cmds.size() == 0 && !cmd.valid);
		wait (owed_points.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && owed_points.size() == 0) begin
			$display("end of test: clean");
		end else begin
			if (owed_points.size() != 0)
				$display("%0t: %0d point beats never arrived", $realtime, owed_points.size());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
